FILE: sv/rbs_pkg.sv
// shared types, constants and functions of the ray box slab intersect block
package rbs_pkg;

  localparam int CoordW   = 32;
  localparam int BoxW     = 32;
  localparam int EpsW     = 31;
  localparam int CfgW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int FracBits = 16;

  localparam int OffW     = ((CoordW > BoxW) ? CoordW : BoxW) + 1;
  localparam int QW       = 33;
  localparam int DivBits  = 3;
  localparam int DivStg   = (QW + DivBits - 1) / DivBits;
  localparam int RemW     = CoordW + 1;
  localparam int RW       = 36;
  localparam int RHalf    = RW / 2;
  localparam int TW       = 48;
  localparam int PW       = OffW + RW;
  localparam int MW       = PW - FracBits;
  localparam int NStg     = DivStg + 5;

  localparam logic [RW-1:0] ZeroRecip = RW'(64'd65536000000);
  localparam logic [MW-1:0] SatPos    = MW'((64'd1 << (TW - 1)) - 64'd1);
  localparam logic [MW-1:0] SatNeg    = MW'(64'd1 << (TW - 1));

  localparam logic signed [BoxW-1:0] BoxMinRst = BoxW'(-65536);
  localparam logic signed [BoxW-1:0] BoxMaxRst = BoxW'(65536);
  localparam logic [EpsW-1:0]        EpsRst    = EpsW'(66);

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MAX_X = 3'd1,
    REG_BOX_MIN_Y = 3'd2,
    REG_BOX_MAX_Y = 3'd3,
    REG_BOX_MIN_Z = 3'd4,
    REG_BOX_MAX_Z = 3'd5,
    REG_EXIT_EPS  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QW-1:0]   quo;
  } div_t;

  // restoring division of 2^32 by dmag, DivBits quotient bits per call
  function automatic div_t div_step(div_t cur, logic [CoordW-1:0] dmag, int unsigned stg);
    div_t            r;
    logic [RemW-1:0] tmp;
    int unsigned     j;
    logic            qb;
    r = cur;
    for (int b = 0; b < DivBits; b++) begin
      j = stg * DivBits + b;
      if (j < QW) begin
        tmp = {r.rem[RemW-2:0], (j == 0)};
        qb  = (tmp >= RemW'(dmag));
        r.rem = qb ? (tmp - RemW'(dmag)) : tmp;
        r.quo = {r.quo[QW-2:0], qb};
      end
    end
    return r;
  endfunction

  function automatic logic signed [TW-1:0] sat_t(logic [MW-1:0] m, logic neg);
    logic signed [TW-1:0] r;
    if (neg) begin
      if (m > SatNeg) r = $signed(SatNeg[TW-1:0]);
      else r = -$signed(m[TW-1:0]);
    end else begin
      if (m > SatPos) r = $signed(SatPos[TW-1:0]);
      else r = $signed(m[TW-1:0]);
    end
    return r;
  endfunction

endpackage

FILE: sv/rbs_recip.sv
// pipelined reciprocal divider for one axis, carrying the axis plane offsets
module rbs_recip (
  input  logic                               clk_i,
  input  logic [rbs_pkg::DivStg-1:0]         en_i,
  input  logic [rbs_pkg::CoordW-1:0]         dmag_i,
  input  logic                               dneg_i,
  input  logic                               dzero_i,
  input  logic signed [rbs_pkg::OffW-1:0]    off_lo_i,
  input  logic signed [rbs_pkg::OffW-1:0]    off_hi_i,
  output logic [rbs_pkg::QW-1:0]             quo_o,
  output logic                               dneg_o,
  output logic                               dzero_o,
  output logic signed [rbs_pkg::OffW-1:0]    off_lo_o,
  output logic signed [rbs_pkg::OffW-1:0]    off_hi_o
);

  rbs_pkg::div_t                      dv_q    [rbs_pkg::DivStg];
  logic [rbs_pkg::CoordW-1:0]         dmag_q  [rbs_pkg::DivStg];
  logic                               dneg_q  [rbs_pkg::DivStg];
  logic                               dzero_q [rbs_pkg::DivStg];
  logic signed [rbs_pkg::OffW-1:0]    offlo_q [rbs_pkg::DivStg];
  logic signed [rbs_pkg::OffW-1:0]    offhi_q [rbs_pkg::DivStg];

  for (genvar s = 0; s < rbs_pkg::DivStg; s++) begin : g_stg
    rbs_pkg::div_t                   cur_dv;
    logic [rbs_pkg::CoordW-1:0]      cur_dmag;
    logic                            cur_dneg;
    logic                            cur_dzero;
    logic signed [rbs_pkg::OffW-1:0] cur_offlo;
    logic signed [rbs_pkg::OffW-1:0] cur_offhi;

    if (s == 0) begin : g_first
      assign cur_dv    = '0;
      assign cur_dmag  = dmag_i;
      assign cur_dneg  = dneg_i;
      assign cur_dzero = dzero_i;
      assign cur_offlo = off_lo_i;
      assign cur_offhi = off_hi_i;
    end else begin : g_next
      assign cur_dv    = dv_q[s-1];
      assign cur_dmag  = dmag_q[s-1];
      assign cur_dneg  = dneg_q[s-1];
      assign cur_dzero = dzero_q[s-1];
      assign cur_offlo = offlo_q[s-1];
      assign cur_offhi = offhi_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        dv_q[s]    <= rbs_pkg::div_step(cur_dv, cur_dmag, s);
        dmag_q[s]  <= cur_dmag;
        dneg_q[s]  <= cur_dneg;
        dzero_q[s] <= cur_dzero;
        offlo_q[s] <= cur_offlo;
        offhi_q[s] <= cur_offhi;
      end
    end
  end

  assign quo_o    = dv_q[rbs_pkg::DivStg-1].quo;
  assign dneg_o   = dneg_q[rbs_pkg::DivStg-1];
  assign dzero_o  = dzero_q[rbs_pkg::DivStg-1];
  assign off_lo_o = offlo_q[rbs_pkg::DivStg-1];
  assign off_hi_o = offhi_q[rbs_pkg::DivStg-1];

endmodule

FILE: sv/rbs_dist.sv
// two stage plane distance: split multiply, then sum, saturate and order
module rbs_dist (
  input  logic                            clk_i,
  input  logic                            en_a_i,
  input  logic                            en_b_i,
  input  logic [rbs_pkg::QW-1:0]          quo_i,
  input  logic                            dneg_i,
  input  logic                            dzero_i,
  input  logic signed [rbs_pkg::OffW-1:0] off_lo_i,
  input  logic signed [rbs_pkg::OffW-1:0] off_hi_i,
  output logic signed [rbs_pkg::TW-1:0]   t_in_o,
  output logic signed [rbs_pkg::TW-1:0]   t_out_o
);

  localparam int PpW = rbs_pkg::OffW + rbs_pkg::RHalf;

  logic [rbs_pkg::RW-1:0]            rmag;
  logic                              rneg;
  logic signed [rbs_pkg::OffW-1:0]   off    [2];
  logic [rbs_pkg::OffW-1:0]          amag   [2];
  logic [PpW-1:0]                    pplo_d [2];
  logic [PpW-1:0]                    pphi_d [2];
  logic [PpW-1:0]                    pplo_q [2];
  logic [PpW-1:0]                    pphi_q [2];
  logic                              pneg_q [2];
  logic                              rneg_q;
  logic [rbs_pkg::PW-1:0]            prod   [2];
  logic signed [rbs_pkg::TW-1:0]     t_pl   [2];
  logic signed [rbs_pkg::TW-1:0]     tin_q;
  logic signed [rbs_pkg::TW-1:0]     tout_q;

  assign rmag = dzero_i ? rbs_pkg::ZeroRecip : rbs_pkg::RW'(quo_i);
  assign rneg = dneg_i && !dzero_i && (quo_i != '0);
  assign off[0] = off_lo_i;
  assign off[1] = off_hi_i;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      amag[p]   = off[p][rbs_pkg::OffW-1] ? rbs_pkg::OffW'(-off[p]) : rbs_pkg::OffW'(off[p]);
      pplo_d[p] = PpW'(amag[p]) * PpW'(rmag[rbs_pkg::RHalf-1:0]);
      pphi_d[p] = PpW'(amag[p]) * PpW'(rmag[rbs_pkg::RW-1:rbs_pkg::RHalf]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      for (int p = 0; p < 2; p++) begin
        pplo_q[p] <= pplo_d[p];
        pphi_q[p] <= pphi_d[p];
        pneg_q[p] <= off[p][rbs_pkg::OffW-1] ^ rneg;
      end
      rneg_q <= rneg;
    end
  end

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      prod[p] = rbs_pkg::PW'(pplo_q[p]) + (rbs_pkg::PW'(pphi_q[p]) << rbs_pkg::RHalf);
      t_pl[p] = rbs_pkg::sat_t(prod[p][rbs_pkg::PW-1:rbs_pkg::FracBits], pneg_q[p]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      tin_q  <= rneg_q ? t_pl[1] : t_pl[0];
      tout_q <= rneg_q ? t_pl[0] : t_pl[1];
    end
  end

  assign t_in_o  = tin_q;
  assign t_out_o = tout_q;

endmodule

FILE: sv/ray_box_slab_intersect.sv
// top level: ray versus box slab test pipeline with configuration registers
// Accepts one ray per clock cycle while in_stall_o is low and returns one hit flag per ray,
// in order. The pipeline is an input stage, then the reciprocal divider, 11 stages that each
// resolve 3 quotient bits, then a two stage split multiply, the entry/exit reduction and the
// final compare. A stalled output does not freeze the pipeline at once: empty stages keep
// filling, and input stall rises only when every stage holds a ray. The user writes box bounds
// and epsilon via the configuration port only while no ray is in flight; this is not enforced.
module ray_box_slab_intersect (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [rbs_pkg::CoordW-1:0] origin_x_i,
  input  logic signed [rbs_pkg::CoordW-1:0] origin_y_i,
  input  logic signed [rbs_pkg::CoordW-1:0] origin_z_i,
  input  logic signed [rbs_pkg::CoordW-1:0] dir_x_i,
  input  logic signed [rbs_pkg::CoordW-1:0] dir_y_i,
  input  logic signed [rbs_pkg::CoordW-1:0] dir_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  input  logic                              cfg_we_i,
  input  logic [rbs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rbs_pkg::CfgW-1:0]          cfg_wdata_i
);

  localparam int SDistA = rbs_pkg::DivStg + 1;
  localparam int SDistB = rbs_pkg::DivStg + 2;
  localparam int SMinMax = rbs_pkg::DivStg + 3;
  localparam int SOut = rbs_pkg::DivStg + 4;

  logic signed [rbs_pkg::BoxW-1:0]   bmin_q [3];
  logic signed [rbs_pkg::BoxW-1:0]   bmax_q [3];
  logic [rbs_pkg::EpsW-1:0]          eps_q;

  logic [rbs_pkg::NStg-1:0]          v_q;
  logic [rbs_pkg::NStg-1:0]          en;

  logic signed [rbs_pkg::CoordW-1:0] org    [3];
  logic signed [rbs_pkg::CoordW-1:0] dir    [3];
  logic [rbs_pkg::CoordW-1:0]        dmag_q [3];
  logic                              dneg_q [3];
  logic                              dzero_q[3];
  logic signed [rbs_pkg::OffW-1:0]   offlo_q[3];
  logic signed [rbs_pkg::OffW-1:0]   offhi_q[3];

  logic signed [rbs_pkg::TW-1:0]     t_in   [3];
  logic signed [rbs_pkg::TW-1:0]     t_out  [3];
  logic signed [rbs_pkg::TW-1:0]     t0_d;
  logic signed [rbs_pkg::TW-1:0]     t1_d;
  logic signed [rbs_pkg::TW-1:0]     t0_q;
  logic signed [rbs_pkg::TW-1:0]     t1_q;
  logic signed [rbs_pkg::TW-1:0]     eps_t;
  logic                              hit_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        bmin_q[a] <= rbs_pkg::BoxMinRst;
        bmax_q[a] <= rbs_pkg::BoxMaxRst;
      end
      eps_q <= rbs_pkg::EpsRst;
    end else if (cfg_we_i) begin
      case (rbs_pkg::cfg_reg_e'(cfg_index_i))
        rbs_pkg::REG_BOX_MIN_X: bmin_q[0] <= $signed(cfg_wdata_i[rbs_pkg::BoxW-1:0]);
        rbs_pkg::REG_BOX_MAX_X: bmax_q[0] <= $signed(cfg_wdata_i[rbs_pkg::BoxW-1:0]);
        rbs_pkg::REG_BOX_MIN_Y: bmin_q[1] <= $signed(cfg_wdata_i[rbs_pkg::BoxW-1:0]);
        rbs_pkg::REG_BOX_MAX_Y: bmax_q[1] <= $signed(cfg_wdata_i[rbs_pkg::BoxW-1:0]);
        rbs_pkg::REG_BOX_MIN_Z: bmin_q[2] <= $signed(cfg_wdata_i[rbs_pkg::BoxW-1:0]);
        rbs_pkg::REG_BOX_MAX_Z: bmax_q[2] <= $signed(cfg_wdata_i[rbs_pkg::BoxW-1:0]);
        rbs_pkg::REG_EXIT_EPS:  eps_q <= cfg_wdata_i[rbs_pkg::EpsW-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it or any later stage is empty, or the output drains
  always_comb begin
    for (int k = 0; k < rbs_pkg::NStg; k++) begin
      en[k] = !out_stall_i || ((~v_q & ({rbs_pkg::NStg{1'b1}} << k)) != '0);
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < rbs_pkg::NStg; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  // input stage: plane offsets and direction magnitude
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        dmag_q[a]  <= dir[a][rbs_pkg::CoordW-1] ? rbs_pkg::CoordW'(-dir[a])
                                                : rbs_pkg::CoordW'(dir[a]);
        dneg_q[a]  <= dir[a][rbs_pkg::CoordW-1];
        dzero_q[a] <= (dir[a] == '0);
        offlo_q[a] <= rbs_pkg::OffW'(bmin_q[a]) - rbs_pkg::OffW'(org[a]);
        offhi_q[a] <= rbs_pkg::OffW'(bmax_q[a]) - rbs_pkg::OffW'(org[a]);
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [rbs_pkg::QW-1:0]          quo;
    logic                            rdneg;
    logic                            rdzero;
    logic signed [rbs_pkg::OffW-1:0] roff_lo;
    logic signed [rbs_pkg::OffW-1:0] roff_hi;

    rbs_recip u_recip (
      .clk_i    (clk_i),
      .en_i     (en[rbs_pkg::DivStg:1]),
      .dmag_i   (dmag_q[a]),
      .dneg_i   (dneg_q[a]),
      .dzero_i  (dzero_q[a]),
      .off_lo_i (offlo_q[a]),
      .off_hi_i (offhi_q[a]),
      .quo_o    (quo),
      .dneg_o   (rdneg),
      .dzero_o  (rdzero),
      .off_lo_o (roff_lo),
      .off_hi_o (roff_hi)
    );

    rbs_dist u_dist (
      .clk_i    (clk_i),
      .en_a_i   (en[SDistA]),
      .en_b_i   (en[SDistB]),
      .quo_i    (quo),
      .dneg_i   (rdneg),
      .dzero_i  (rdzero),
      .off_lo_i (roff_lo),
      .off_hi_i (roff_hi),
      .t_in_o   (t_in[a]),
      .t_out_o  (t_out[a])
    );
  end

  // largest entry, smallest exit
  always_comb begin
    t0_d = (t_in[0] > t_in[1]) ? t_in[0] : t_in[1];
    if (t_in[2] > t0_d) t0_d = t_in[2];
    t1_d = (t_out[0] < t_out[1]) ? t_out[0] : t_out[1];
    if (t_out[2] < t1_d) t1_d = t_out[2];
  end

  always_ff @(posedge clk_i) begin
    if (en[SMinMax]) begin
      t0_q <= t0_d;
      t1_q <= t1_d;
    end
  end

  assign eps_t = rbs_pkg::TW'($signed({1'b0, eps_q}));

  always_ff @(posedge clk_i) begin
    if (en[SOut]) hit_q <= (t0_q < t1_q) && (t1_q > eps_t);
  end

  assign out_valid_o = v_q[SOut];
  assign hit_o       = hit_q;

endmodule

FILE: sv/rbs_checker.sv
// port level checks of the ray box slab intersect block and their bind
module rbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic hit_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(hit_o)))
    else $error("stalled result changed");

  // input backs up only behind a full pipeline with a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while pipeline can move");

  // a full pipeline frees only when a result leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> !out_stall_i)
    else $error("input stall released without an output transaction");

endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o)
);

FILE: dv/testbench.sv
// testbench for the ray box slab intersect block: directed table, random rays, box settings
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TPos = 64'h7FFF_FFFF_FFFF;
  localparam longint TNeg = 64'h8000_0000_0000;
  localparam int WatchLimit = 20000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, hit_o;
  logic signed [rbs_pkg::CoordW-1:0] origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i;
  logic cfg_we_i;
  logic [rbs_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [rbs_pkg::CfgW-1:0] cfg_wdata_i;

  ray_box_slab_intersect uut (.*);

  typedef struct {
    logic signed [rbs_pkg::CoordW-1:0] o[3];
    logic signed [rbs_pkg::CoordW-1:0] d[3];
    int exp_hit;  // -1 means use the predictor
  } ray_t;

  longint box_lo[3], box_hi[3];
  longint eps_q;
  bit hit_queue[$];
  int errors;
  int idle_cycles;
  bit long_hold;
  bit stim_done;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint sat_mag(longint unsigned m, bit neg);
    if (neg) return (m > TNeg) ? -TNeg : -longint'(m);
    return (m > TPos) ? TPos : longint'(m);
  endfunction

  function automatic longint magn(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint inv_dir(longint d);
    if (d == 0) return 64'd65536000000;
    return sat_mag((64'd1 << 32) / magn(d), d < 0);
  endfunction

  function automatic longint slab_dist(longint off, longint r);
    longint unsigned a, b, q;
    a = magn(off);
    b = magn(r);
    if (b != 0 && a > 64'h7FFF_FFFF_FFFF_FFFF / b) q = TNeg + 1;
    else q = (a * b) >> 16;
    return sat_mag(q, (off < 0) != (r < 0));
  endfunction

  function automatic bit ray_hits(ray_t ry);
    longint t_near, t_far, r, tl, th, tin, tout;
    t_near = -(64'sd1 << 62);
    t_far = 64'sd1 << 62;
    for (int a = 0; a < 3; a++) begin
      r = inv_dir(longint'(ry.d[a]));
      tl = slab_dist(box_lo[a] - longint'(ry.o[a]), r);
      th = slab_dist(box_hi[a] - longint'(ry.o[a]), r);
      tin = (r >= 0) ? tl : th;
      tout = (r >= 0) ? th : tl;
      if (a == 0 || tin > t_near) t_near = tin;
      if (a == 0 || tout < t_far) t_far = tout;
    end
    return (t_near < t_far) && (t_far > eps_q);
  endfunction

  task automatic write_reg(rbs_pkg::cfg_reg_e idx, logic [rbs_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rbs_pkg::REG_EXIT_EPS) eps_q = longint'(val[rbs_pkg::EpsW-1:0]);
    else if (idx[0]) box_hi[idx >> 1] = longint'($signed(val));
    else box_lo[idx >> 1] = longint'($signed(val));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (hit_queue.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic send_ray(ray_t ry);
    bit h;
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2))
        @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ry.o[0]; origin_y_i <= ry.o[1]; origin_z_i <= ry.o[2];
    dir_x_i <= ry.d[0]; dir_y_i <= ry.d[1]; dir_z_i <= ry.d[2];
    h = ray_hits(ry);
    if (ry.exp_hit >= 0 && ry.exp_hit != int'(h)) begin
      $display("%0t table row disagrees with predictor: expected %0d actual %0d",
               $time, ry.exp_hit, h);
      errors++;
    end
    do @(posedge clk_i); while (in_stall_o);
    hit_queue.push_back(h);
    @(negedge clk_i);
  endtask

  function automatic logic signed [rbs_pkg::CoordW-1:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 262144)) - 131072;
      2: return 0;
      default: return $signed($urandom_range(0, 1024)) - 512;
    endcase
  endfunction

  function automatic ray_t rnd_ray();
    ray_t ry;
    int m;
    m = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      ry.o[a] = (m == 0) ? rnd_coord(0) : rnd_coord($urandom_range(1, 2) == 1 ? 1 : 2);
      case ($urandom_range(0, 7))
        0: ry.d[a] = 0;
        1: ry.d[a] = $urandom();
        2: ry.d[a] = rnd_coord(3);
        default: ry.d[a] = rnd_coord(1);
      endcase
      if ($urandom_range(0, 1)) ry.d[a] = -(ry.o[a] >>> $urandom_range(0, 4)) + rnd_coord(3);
    end
    ry.exp_hit = -1;
    return ry;
  endfunction

  function automatic ray_t mk(longint ox, longint oy, longint oz,
                              longint dx, longint dy, longint dz, int e);
    ray_t ry;
    ry.o[0] = rbs_pkg::CoordW'(ox);
    ry.o[1] = rbs_pkg::CoordW'(oy);
    ry.o[2] = rbs_pkg::CoordW'(oz);
    ry.d[0] = rbs_pkg::CoordW'(dx);
    ry.d[1] = rbs_pkg::CoordW'(dy);
    ry.d[2] = rbs_pkg::CoordW'(dz);
    ry.exp_hit = e;
    return ry;
  endfunction

  // output side: random stalls, one long hold-off
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (60) @(negedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat (($urandom_range(0, 12) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 2))
          @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 30) == 0) begin
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hit_queue.size() == 0) begin
        $display("%0t unexpected hit flag: expected none actual %0b", $time, hit_o);
        errors++;
      end else begin
        if (hit_o !== hit_queue[0]) begin
          $display("%0t hit mismatch: expected %0b actual %0b", $time, hit_queue[0], hit_o);
          errors++;
        end
        void'(hit_queue.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni
        || (stim_done && hit_queue.size() == 0) || (!in_valid_i && hit_queue.size() == 0))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    ray_t table_rows[$];
    errors = 0; idle_cycles = 0; long_hold = 0; stim_done = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; cfg_we_i = 1'b0; cfg_index_i = '0; cfg_wdata_i = '0;
    origin_x_i = '0; origin_y_i = '0; origin_z_i = '0;
    dir_x_i = '0; dir_y_i = '0; dir_z_i = '0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = -65536; box_hi[a] = 65536;
    end
    eps_q = 66;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset box: cube from -1.0 to 1.0 on each axis around origin
    table_rows.push_back(mk(-196608, 0, 0, 65536, 0, 0, 1));
    table_rows.push_back(mk(-196608, 0, 0, -65536, 0, 0, 0));
    table_rows.push_back(mk(0, 0, 0, 0, 0, 0, 1));
    table_rows.push_back(mk(196608, 196608, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(0, 0, -196608, 0, 0, 65536, 1));
    table_rows.push_back(mk(0, 0, -196608, 65536, 0, 0, 0));
    table_rows.push_back(mk(0, -196608, 0, 0, 65536, 0, 1));
    table_rows.push_back(mk(65536, 0, 0, 65536, 0, 0, 0));
    table_rows.push_back(mk(-65536, 0, 0, -65536, 0, 0, 0));
    table_rows.push_back(mk(0, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -1));
    table_rows.push_back(mk(0, 0, 0, -32'sh80000000, -32'sh80000000, -32'sh80000000, -1));
    table_rows.push_back(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -1, -1, -1, -1));
    table_rows.push_back(mk(-32'sh80000000, -32'sh80000000, -32'sh80000000, 1, 1, 1, -1));
    table_rows.push_back(mk(-32'sh80000000, 0, 0, 32'sh7FFFFFFF, 0, 0, -1));
    table_rows.push_back(mk(0, 0, 0, 1, -1, 1, -1));
    table_rows.push_back(mk(-131072, -131072, 0, 65536, 65536, 0, -1));
    foreach (table_rows[i]) send_ray(table_rows[i]);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(rbs_pkg::REG_BOX_MIN_X, 32'h8000_0000);
          write_reg(rbs_pkg::REG_BOX_MAX_X, 32'h7FFF_FFFF);
          write_reg(rbs_pkg::REG_BOX_MIN_Y, 32'h8000_0000);
          write_reg(rbs_pkg::REG_BOX_MAX_Y, 32'h7FFF_FFFF);
          write_reg(rbs_pkg::REG_BOX_MIN_Z, 32'h8000_0000);
          write_reg(rbs_pkg::REG_BOX_MAX_Z, 32'h7FFF_FFFF);
          write_reg(rbs_pkg::REG_EXIT_EPS, 32'h0);
        end
        1: write_reg(rbs_pkg::REG_EXIT_EPS, 32'h7FFF_FFFF);
        2: begin
          write_reg(rbs_pkg::REG_EXIT_EPS, 32'hFFFF_FFFF);
          write_reg(rbs_pkg::REG_BOX_MIN_X, 0); write_reg(rbs_pkg::REG_BOX_MAX_X, 0);
        end
        default: begin
          for (int a = 0; a < 3; a++) begin
            int lo, hi;
            lo = $signed($urandom_range(0, 200000)) - 100000;
            hi = lo + $urandom_range(0, 150000);
            write_reg(rbs_pkg::cfg_reg_e'(2 * a), lo);
            write_reg(rbs_pkg::cfg_reg_e'(2 * a + 1), hi);
          end
          write_reg(rbs_pkg::REG_EXIT_EPS,
                    $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 500));
        end
      endcase
      for (int n = 0; n < (ph < 3 ? 60 : 220); n++) begin
        if (ph == 3 && n == 20) long_hold = 1'b1;
        send_ray(rnd_ray());
      end
      wait_drained();
    end
    stim_done = 1'b1;
    wait_drained();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
